// ----- rtl/core/alle_pkg.sv -----
// Shared types, codes and defaults of the array linked list engine.
`timescale 1ns / 1ps

package alle_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_INS_AFTER  = 2'd0,
		OP_INS_BEFORE = 2'd1,
		OP_DELETE     = 2'd2,
		OP_READ       = 2'd3
	} alle_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_SLOT = 2'd2,
		ST_RANGE    = 2'd3
	} alle_status_t;

	typedef enum logic [1:0] {
		ALU_INC = 2'd0,
		ALU_DEC = 2'd1,
		ALU_LT  = 2'd2,
		ALU_EQ  = 2'd3
	} alle_alu_op_t;

	// write enables of the slot tables
	typedef struct packed {
		logic h;
		logic t;
		logic u;
		logic d;
	} alle_we_t;

endpackage

// ----- rtl/core/alle_alu.sv -----
// Shared slot-index unit: increment, decrement, less-than and equality.
`timescale 1ns / 1ps

module alle_alu #(
	parameter int W = 4
) (
	input  logic                  [W-1:0] a,
	input  logic                  [W-1:0] b,
	input  alle_pkg::alle_alu_op_t        op,
	output logic                  [W-1:0] y
);

	always_comb begin
		unique case (op)
			alle_pkg::ALU_INC: y = a + W'(1);
			alle_pkg::ALU_DEC: y = a - W'(1);
			alle_pkg::ALU_LT:  y = W'(a < b);
			alle_pkg::ALU_EQ:  y = W'(a == b);
			default:           y = '0;
		endcase
	end

endmodule

// ----- rtl/core/alle_tables.sv -----
// Slot tables: link toward head, link toward tail, in-use bits and data words.
`timescale 1ns / 1ps

module alle_tables #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PTR_W      = 4
) (
	input  logic                      clk,
	input  alle_pkg::alle_we_t        we,
	input  logic [PTR_W-1:0]          h_wa,
	input  logic [PTR_W-1:0]          h_wd,
	input  logic [PTR_W-1:0]          t_wa,
	input  logic [PTR_W-1:0]          t_wd,
	input  logic [PTR_W-1:0]          ud_wa,   // shared by in-use bits and data
	input  logic                      u_wd,
	input  logic [DATA_WIDTH-1:0]     d_wd,
	input  logic [PTR_W-1:0]          h_ra,
	input  logic [PTR_W-1:0]          pos_ra,  // tail links and in-use bits
	input  logic [PTR_W-1:0]          d_ra,
	output logic [PTR_W-1:0]          rd_h_q,
	output logic [PTR_W-1:0]          rd_t_q,
	output logic                      rd_u_q,
	output logic [DATA_WIDTH-1:0]     rd_d_q
);

	logic [PTR_W-1:0]      h_mem [CAPACITY];
	logic [PTR_W-1:0]      t_mem [CAPACITY];
	logic                  u_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] d_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we.h) h_mem[h_wa] <= h_wd;
		if (we.t) t_mem[t_wa] <= t_wd;
		if (we.u) u_mem[ud_wa] <= u_wd;
		if (we.d) d_mem[ud_wa] <= d_wd;
		rd_h_q <= h_mem[h_ra];
		rd_t_q <= t_mem[pos_ra];
		rd_u_q <= u_mem[pos_ra];
		rd_d_q <= d_mem[d_ra];
	end

endmodule

// ----- rtl/core/alle_seq.sv -----
// Operation sequencer: list registers, table access order and result build.
`timescale 1ns / 1ps

module alle_seq #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PTR_W      = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  alle_pkg::alle_op_t           in_op,
	input  logic [PTR_W-1:0]             in_pos,
	input  logic [DATA_WIDTH-1:0]        in_value,
	input  logic [PTR_W-1:0]             in_lidx,
	output logic                         res_valid,
	input  logic                         res_ready,
	output alle_pkg::alle_status_t       res_status,
	output logic [PTR_W-1:0]             res_slot,
	output logic [DATA_WIDTH-1:0]        res_value,
	output logic [PTR_W-1:0]             res_count,
	output alle_pkg::alle_we_t           we,
	output logic [PTR_W-1:0]             h_wa,
	output logic [PTR_W-1:0]             h_wd,
	output logic [PTR_W-1:0]             t_wa,
	output logic [PTR_W-1:0]             t_wd,
	output logic [PTR_W-1:0]             ud_wa,
	output logic                         u_wd,
	output logic [DATA_WIDTH-1:0]        d_wd,
	output logic [PTR_W-1:0]             h_ra,
	output logic [PTR_W-1:0]             pos_ra,
	output logic [PTR_W-1:0]             d_ra,
	input  logic [PTR_W-1:0]             rd_h_q,
	input  logic [PTR_W-1:0]             rd_t_q,
	input  logic                         rd_u_q,
	input  logic [DATA_WIDTH-1:0]        rd_d_q
);

	localparam logic [PTR_W-1:0] CAP_M1 = PTR_W'(CAPACITY - 1);
	localparam logic [PTR_W:0]   CAP_X  = (PTR_W + 1)'(CAPACITY);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'h0001,
		S_IDLE   = 13'h0002,
		S_CHECK  = 13'h0004,
		S_FETCH  = 13'h0008,
		S_LOAD   = 13'h0010,
		S_DECIDE = 13'h0020,
		S_WR1    = 13'h0040,
		S_WR2    = 13'h0080,
		S_WR3    = 13'h0100,
		S_WALK   = 13'h0200,
		S_STEP   = 13'h0400,
		S_DATA   = 13'h0800,
		S_FIN    = 13'h1000
	} state_t;

	state_t                 state_q;
	logic [PTR_W-1:0]       clr_q;
	logic [PTR_W-1:0]       head_q;
	logic [PTR_W-1:0]       tail_q;
	logic [PTR_W-1:0]       ffirst_q;
	logic [PTR_W-1:0]       flast_q;
	logic [PTR_W-1:0]       count_q;

	alle_pkg::alle_op_t     op_q;
	logic [PTR_W-1:0]       pos_q;
	logic [DATA_WIDTH-1:0]  val_q;
	logic [PTR_W-1:0]       lidx_q;
	logic [PTR_W-1:0]       lnk_h_q;
	logic [PTR_W-1:0]       lnk_t_q;
	logic                   use_q;
	logic [PTR_W-1:0]       nfree_q;
	logic [PTR_W-1:0]       nslot_q;
	alle_pkg::alle_status_t status_q;
	logic [DATA_WIDTH-1:0]  rval_q;
	logic                   ok_q;
	logic                   full_q;
	logic [PTR_W-1:0]       walk_s_q;
	logic [PTR_W-1:0]       walk_k_q;

	logic [PTR_W-1:0]       alu_a;
	logic [PTR_W-1:0]       alu_b;
	alle_pkg::alle_alu_op_t alu_op;
	logic [PTR_W-1:0]       alu_y;

	logic is_ins;
	logic is_del;
	logic empty;
	logic pos_ok;

	assign is_ins = (op_q == alle_pkg::OP_INS_AFTER) || (op_q == alle_pkg::OP_INS_BEFORE);
	assign is_del = (op_q == alle_pkg::OP_DELETE);
	assign empty  = (count_q == '0);
	assign pos_ok = (pos_q != '0) && ((PTR_W + 1)'(pos_q) < CAP_X) && use_q;

	alle_alu #(.W(PTR_W)) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.y  (alu_y)
	);

	// one index unit, shared by sweep, checks, walk and count update
	always_comb begin
		alu_a  = count_q;
		alu_b  = CAP_M1;
		alu_op = alle_pkg::ALU_EQ;
		unique case (state_q)
			S_CLEAR: begin
				alu_a  = clr_q;
				alu_op = alle_pkg::ALU_INC;
			end
			S_CHECK: begin
				if (op_q == alle_pkg::OP_READ) begin
					alu_a  = lidx_q;
					alu_b  = count_q;
					alu_op = alle_pkg::ALU_LT;
				end
			end
			S_WALK: begin
				alu_a  = walk_k_q;
				alu_op = alle_pkg::ALU_DEC;
			end
			S_FIN: begin
				alu_op = is_del ? alle_pkg::ALU_DEC : alle_pkg::ALU_INC;
			end
			default: ;
		endcase
	end

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_FIN);
	assign res_status = status_q;
	assign res_slot   = nslot_q;
	assign res_value  = rval_q;
	assign res_count  = ok_q ? alu_y : count_q;

	assign pos_ra = pos_q;
	assign d_ra   = walk_s_q;

	always_comb begin
		unique case (state_q)
			S_CHECK: h_ra = is_ins ? ffirst_q : pos_q;
			S_WALK:  h_ra = walk_s_q;
			default: h_ra = pos_q;
		endcase
	end

	// table writes
	always_comb begin
		we    = '0;
		h_wa  = '0;
		h_wd  = '0;
		t_wa  = '0;
		t_wd  = '0;
		ud_wa = '0;
		u_wd  = 1'b0;
		d_wd  = val_q;
		unique case (state_q)
			S_CLEAR: begin
				we.h  = 1'b1;
				we.t  = 1'b1;
				we.u  = 1'b1;
				h_wa  = clr_q;
				t_wa  = clr_q;
				ud_wa = clr_q;
				h_wd  = ((clr_q != '0) && (clr_q != CAP_M1)) ? alu_y : '0;
				u_wd  = (clr_q == '0);
			end
			S_WR1: begin
				if (is_del) begin
					we.h  = (lnk_t_q != '0);
					h_wa  = lnk_t_q;
					h_wd  = lnk_h_q;
					we.t  = (lnk_h_q != '0);
					t_wa  = lnk_h_q;
					t_wd  = lnk_t_q;
					we.u  = 1'b1;
					ud_wa = pos_q;
				end else begin
					we    = '1;
					h_wa  = nslot_q;
					t_wa  = nslot_q;
					ud_wa = nslot_q;
					u_wd  = 1'b1;
					if (!empty) begin
						h_wd = (op_q == alle_pkg::OP_INS_AFTER) ? lnk_h_q : pos_q;
						t_wd = (op_q == alle_pkg::OP_INS_AFTER) ? pos_q : lnk_t_q;
					end
				end
			end
			S_WR2: begin
				if (is_del) begin
					we.h = 1'b1;
					we.t = 1'b1;
					h_wa = pos_q;
					t_wa = pos_q;
				end else if (op_q == alle_pkg::OP_INS_AFTER) begin
					we.h = 1'b1;
					h_wa = pos_q;
					h_wd = nslot_q;
					we.t = (lnk_h_q != '0);
					t_wa = lnk_h_q;
					t_wd = nslot_q;
				end else begin
					we.t = 1'b1;
					t_wa = pos_q;
					t_wd = nslot_q;
					we.h = (lnk_t_q != '0);
					h_wa = lnk_t_q;
					h_wd = nslot_q;
				end
			end
			S_WR3: begin
				we.h = 1'b1;
				h_wa = flast_q;
				h_wd = pos_q;
			end
			default: ;
		endcase
	end

	// control state and list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			ffirst_q <= PTR_W'(1);
			flast_q  <= CAP_M1;
			count_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= alu_y;
					if (clr_q == CAP_M1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					unique case (op_q)
						alle_pkg::OP_READ:   state_q <= alu_y[0] ? S_WALK : S_FIN;
						alle_pkg::OP_DELETE: state_q <= S_LOAD;
						default:             state_q <= alu_y[0] ? S_FIN : S_FETCH;
					endcase
				end
				S_FETCH:  state_q <= S_LOAD;
				S_LOAD:   state_q <= S_DECIDE;
				S_DECIDE: begin
					state_q <= ((is_ins && empty) || pos_ok) ? S_WR1 : S_FIN;
				end
				S_WR1: begin
					if (is_del) begin
						if (pos_q == head_q) head_q <= lnk_t_q;
						if (pos_q == tail_q) tail_q <= lnk_h_q;
						state_q <= S_WR2;
					end else begin
						ffirst_q <= nfree_q;
						if (empty) begin
							head_q  <= nslot_q;
							tail_q  <= nslot_q;
							state_q <= S_FIN;
						end else begin
							state_q <= S_WR2;
						end
					end
				end
				S_WR2: begin
					if (is_del) begin
						if (full_q) begin
							ffirst_q <= pos_q;
							flast_q  <= pos_q;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_WR3;
						end
					end else begin
						if (op_q == alle_pkg::OP_INS_AFTER && pos_q == head_q)
							head_q <= nslot_q;
						if (op_q == alle_pkg::OP_INS_BEFORE && pos_q == tail_q)
							tail_q <= nslot_q;
						state_q <= S_FIN;
					end
				end
				S_WR3: begin
					flast_q <= pos_q;
					state_q <= S_FIN;
				end
				S_WALK:  state_q <= (walk_k_q == '0) ? S_DATA : S_STEP;
				S_STEP:  state_q <= S_WALK;
				S_DATA:  state_q <= S_FIN;
				S_FIN: begin
					if (res_ready) begin
						count_q <= res_count;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-item payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q     <= in_op;
				pos_q    <= in_pos;
				val_q    <= in_value;
				lidx_q   <= in_lidx;
				status_q <= alle_pkg::ST_OK;
				nslot_q  <= '0;
				rval_q   <= '0;
				ok_q     <= 1'b0;
			end
			S_CHECK: begin
				full_q   <= alu_y[0];
				walk_s_q <= tail_q;
				walk_k_q <= lidx_q;
				if (op_q == alle_pkg::OP_READ) begin
					if (!alu_y[0]) status_q <= alle_pkg::ST_RANGE;
				end else if (is_ins && alu_y[0]) begin
					status_q <= alle_pkg::ST_FULL;
				end
			end
			S_FETCH: begin
				nfree_q <= rd_h_q;
				lnk_t_q <= rd_t_q;
				use_q   <= rd_u_q;
			end
			S_LOAD: begin
				lnk_h_q <= rd_h_q;
				if (is_del) begin
					lnk_t_q <= rd_t_q;
					use_q   <= rd_u_q;
				end
			end
			S_DECIDE: begin
				if ((is_ins && empty) || pos_ok) begin
					ok_q <= 1'b1;
					if (is_ins) nslot_q <= ffirst_q;
				end else begin
					status_q <= alle_pkg::ST_BAD_SLOT;
				end
			end
			S_WALK: begin
				walk_k_q <= alu_y;
			end
			S_STEP: begin
				walk_s_q <= rd_h_q;
			end
			S_DATA: begin
				rval_q <= rd_d_q;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_M1)
		else $error("entry count above table size");

	a_ends_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		(((count_q == '0) == (head_q == '0)) && ((count_q == '0) == (tail_q == '0))))
		else $error("list ends disagree with entry count");

	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && (count_q != CAP_M1)) |-> (ffirst_q != '0))
		else $error("free list head is the sentinel while slots are free");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_status != alle_pkg::ST_OK)) |->
		((res_slot == '0) && (res_value == '0) && (res_count == count_q)))
		else $error("error result carries data or changes the count");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_count)))
		else $error("pending result dropped");
`endif

endmodule

// ----- rtl/core/array_linked_list_engine.sv -----
// Top level of the array linked list engine: stream ports and result register.
`timescale 1ns / 1ps

// Doubly linked list kept in a table of CAPACITY slots, slot 0 being the
// sentinel that ends both sides; free slots are chained in a singly linked
// free list. Each input beat carries one operation (tuser): insert after a
// slot, insert before a slot, delete a slot, or read the entry at a logical
// index counted from the tail. Each beat yields exactly one result beat with
// a status in tuser and the taken slot, read word and entry count in tdata.
// After reset the block sweeps the link and in-use tables to their start
// values, one slot per cycle over all CAPACITY slots, and s_tready stays low.
// The block then works on one operation at a time, sequencing a single
// registered read port per table and one shared index unit. A read walks
// the links hop by hop, each hop waiting on the registered link table read.
// s_tready rises again the cycle after the result is registered; a held
// result in the output register only stalls the next operation at its end.

module array_linked_list_engine #(
	parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF,
	localparam int PTR_W     = $clog2(CAPACITY),
	localparam int FIELD_W   = 2 * PTR_W + DATA_WIDTH,
	localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // slot_pos, item_value, logical_index, zero pad
	input  logic [1:0]         s_tuser,   // operation
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // new_slot, read_value, entry_count, zero pad
	output logic [1:0]         m_tuser    // status
);

	// unpacked input fields
	alle_pkg::alle_op_t     in_op;
	logic [PTR_W-1:0]       in_pos;
	logic [DATA_WIDTH-1:0]  in_value;
	logic [PTR_W-1:0]       in_lidx;

	assign in_op    = alle_pkg::alle_op_t'(s_tuser);
	assign in_pos   = s_tdata[PTR_W-1:0];
	assign in_value = s_tdata[PTR_W +: DATA_WIDTH];
	assign in_lidx  = s_tdata[PTR_W + DATA_WIDTH +: PTR_W];

	// sequencer result
	logic                   res_valid;
	logic                   res_ready;
	alle_pkg::alle_status_t res_status;
	logic [PTR_W-1:0]       res_slot;
	logic [DATA_WIDTH-1:0]  res_value;
	logic [PTR_W-1:0]       res_count;

	// table ports
	alle_pkg::alle_we_t     we;
	logic [PTR_W-1:0]       h_wa;
	logic [PTR_W-1:0]       h_wd;
	logic [PTR_W-1:0]       t_wa;
	logic [PTR_W-1:0]       t_wd;
	logic [PTR_W-1:0]       ud_wa;
	logic                   u_wd;
	logic [DATA_WIDTH-1:0]  d_wd;
	logic [PTR_W-1:0]       h_ra;
	logic [PTR_W-1:0]       pos_ra;
	logic [PTR_W-1:0]       d_ra;
	logic [PTR_W-1:0]       rd_h_q;
	logic [PTR_W-1:0]       rd_t_q;
	logic                   rd_u_q;
	logic [DATA_WIDTH-1:0]  rd_d_q;

	// output register
	logic                   m_valid_q;
	alle_pkg::alle_status_t m_status_q;
	logic [PTR_W-1:0]       m_slot_q;
	logic [DATA_WIDTH-1:0]  m_value_q;
	logic [PTR_W-1:0]       m_count_q;

	alle_tables #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.PTR_W      (PTR_W)
	) u_tables (
		.clk    (clk),
		.we     (we),
		.h_wa   (h_wa),
		.h_wd   (h_wd),
		.t_wa   (t_wa),
		.t_wd   (t_wd),
		.ud_wa  (ud_wa),
		.u_wd   (u_wd),
		.d_wd   (d_wd),
		.h_ra   (h_ra),
		.pos_ra (pos_ra),
		.d_ra   (d_ra),
		.rd_h_q (rd_h_q),
		.rd_t_q (rd_t_q),
		.rd_u_q (rd_u_q),
		.rd_d_q (rd_d_q)
	);

	alle_seq #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.PTR_W      (PTR_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (in_op),
		.in_pos     (in_pos),
		.in_value   (in_value),
		.in_lidx    (in_lidx),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_status (res_status),
		.res_slot   (res_slot),
		.res_value  (res_value),
		.res_count  (res_count),
		.we         (we),
		.h_wa       (h_wa),
		.h_wd       (h_wd),
		.t_wa       (t_wa),
		.t_wd       (t_wd),
		.ud_wa      (ud_wa),
		.u_wd       (u_wd),
		.d_wd       (d_wd),
		.h_ra       (h_ra),
		.pos_ra     (pos_ra),
		.d_ra       (d_ra),
		.rd_h_q     (rd_h_q),
		.rd_t_q     (rd_t_q),
		.rd_u_q     (rd_u_q),
		.rd_d_q     (rd_d_q)
	);

	// result register frees the sequencer while the beat waits downstream
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_status_q <= res_status;
			m_slot_q   <= res_slot;
			m_value_q  <= res_value;
			m_count_q  <= res_count;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = TDATA_W'({m_count_q, m_value_q, m_slot_q});

endmodule
